[rtl/assert_macros.svh]
// assertion helpers used by the sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition in this cycle implies a condition in the next
`define SFS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/sfs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sfs_pkg;

  localparam int unsigned FRAME_BITS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF  = 32;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SPEED_W    = 12;

  localparam logic [15:0]        FRAME_COUNT_RST = 16'd1;
  localparam logic [15:0]        INTERVAL_RST    = 16'd33;
  localparam logic [SPEED_W-1:0] SPEED_RST       = 12'd256;
  localparam logic [SPEED_W-1:0] SPEED_MIN       = 12'd26;
  localparam logic [SPEED_W-1:0] SPEED_MAX       = 12'd2560;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_FRAME_COUNT = 2'd0,
    CFG_INTERVAL    = 2'd1,
    CFG_SPEED       = 2'd2,
    CFG_SPRITE_OK   = 2'd3
  } cfg_index_e;

  // command kinds; codes above KIND_RESET_STATS do nothing
  typedef enum logic [3:0] {
    KIND_TICK        = 4'd0,
    KIND_PLAY        = 4'd1,
    KIND_PAUSE       = 4'd2,
    KIND_RESUME      = 4'd3,
    KIND_STOP        = 4'd4,
    KIND_GOTO        = 4'd5,
    KIND_NEXT        = 4'd6,
    KIND_PREV        = 4'd7,
    KIND_RESET_STATS = 4'd8
  } cmd_kind_e;

  typedef enum logic [1:0] {
    MODE_ONCE = 2'd0,
    MODE_LOOP = 2'd1,
    MODE_PING = 2'd2,
    MODE_ALT  = 2'd3
  } loop_mode_e;

  typedef enum logic [1:0] {
    RUN_LOADED  = 2'd0,
    RUN_PLAYING = 2'd1,
    RUN_PAUSED  = 2'd2,
    RUN_ERROR   = 2'd3
  } run_state_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] now_ms;
    logic [1:0]  loop_mode;
    logic [15:0] target_frame;
  } cmd_item_t;

  typedef struct packed {
    logic [15:0] frame_index;
    run_state_e  run_state;
    logic        advanced;
    logic        accepted;
    logic        redraw;
    logic [31:0] frames_played;
  } res_item_t;

endpackage

`default_nettype wire

[rtl/sprite_frame_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Sprite animation frame sequencer. Each command item (tick, play, pause, resume,
// stop, goto, next, prev, reset stats) gives exactly one result item with the frame
// index, run state, advanced/accepted/redraw flags and the frames-played count.
// A tick while playing advances the frame once now_ms minus the last advance time
// reaches (frame_interval_ms * 256) / speed_q8, truncated. Once mode stops after
// the last frame, loop mode wraps, ping-pong reverses at both ends. Speed writes
// are clamped to 26..2560. With sprite_ok at 0 every item is ignored and reports
// the error state. Timing: every item runs the frame-time quotient through one
// 24-step restoring divider (one quotient bit per cycle) and then one update step
// that registers the result; the next item is taken only after that, in idle.
// The update step waits only while the previous result has not been taken yet.
// in_ready_o is high only while the sequencer is idle; a finished result sits in
// the output register and does not hold up the next item. Configuration must be
// written only while idle; the block itself does not enforce this.
module sprite_frame_sequencer #(
  parameter int unsigned FRAME_BITS = sfs_pkg::FRAME_BITS_DEF,
  parameter int unsigned TIME_BITS  = sfs_pkg::TIME_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // command channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire sfs_pkg::cmd_item_t            in_item_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output sfs_pkg::res_item_t                 out_item_o,
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned FC_W     = FRAME_BITS + 1;
  localparam int unsigned SPEED_W  = sfs_pkg::SPEED_W;
  localparam int unsigned QUO_W    = 24;                 // interval << 8
  localparam int unsigned CNT_W    = $clog2(QUO_W);
  localparam int unsigned CMP_W    = (TIME_BITS > QUO_W) ? TIME_BITS : QUO_W;
  localparam logic [16:0] FRAME_LIMIT = 17'(1) << FRAME_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } seq_state_e;

  seq_state_e state_q, state_d;

  // configuration
  logic [15:0]        frame_count_q, frame_count_d;
  logic [15:0]        interval_q, interval_d;
  logic [SPEED_W-1:0] speed_q, speed_d;
  logic               sprite_ok_q, sprite_ok_d;

  // sequencer state
  sfs_pkg::run_state_e run_q, run_d;
  sfs_pkg::loop_mode_e mode_q, mode_d;
  logic [FRAME_BITS-1:0] cur_q, cur_d;
  logic                  rev_q, rev_d;
  logic [TIME_BITS-1:0]  last_q, last_d;
  logic [31:0]           played_q, played_d;

  // divider and captured command
  sfs_pkg::cmd_item_t cmd_q, cmd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SPEED_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0]   quo_q, quo_d;
  logic [SPEED_W:0]   div_sh;
  logic               div_ge;

  // result register
  logic               out_valid_q, out_valid_d;
  sfs_pkg::res_item_t out_q, out_d;

  // frame math
  logic [16:0]           fc_raw;
  logic [FC_W-1:0]       fc_eff;
  logic [FC_W-1:0]       cur_ext;
  logic [FC_W-1:0]       inc_ext;
  logic [FRAME_BITS-1:0] cur_sat;
  logic [FRAME_BITS-1:0] fc_m1;
  logic [FRAME_BITS-1:0] fc_m2;
  logic [FRAME_BITS-1:0] wrap_nx;
  logic [FRAME_BITS-1:0] prev_nx;
  logic [FRAME_BITS-1:0] ping_nx;
  logic                  ping_rev;
  logic [FRAME_BITS-1:0] tick_nx;
  logic                  tick_rev;
  logic [TIME_BITS-1:0]  now_t;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  due;
  logic                  can_finish;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // one restoring divide step
  assign div_sh = {rem_q, quo_q[QUO_W-1]};
  assign div_ge = (div_sh >= {1'b0, speed_q});

  assign now_t = cmd_q.now_ms[TIME_BITS-1:0];

  always_comb begin
    // effective frame count: zero reads as one, capped at the index range
    if (frame_count_q == 16'd0) begin
      fc_raw = 17'd1;
    end else if ({1'b0, frame_count_q} > FRAME_LIMIT) begin
      fc_raw = FRAME_LIMIT;
    end else begin
      fc_raw = {1'b0, frame_count_q};
    end
    fc_eff = FC_W'(fc_raw);
    fc_m1  = FRAME_BITS'(fc_eff - FC_W'(1));
    fc_m2  = FRAME_BITS'(fc_eff - FC_W'(2));

    // pull a stale frame back inside a shrunken sheet
    cur_ext = {1'b0, cur_q};
    cur_sat = (cur_ext >= fc_eff) ? fc_m1 : cur_q;
    inc_ext = {1'b0, cur_sat} + FC_W'(1);
    wrap_nx = (inc_ext >= fc_eff) ? '0 : FRAME_BITS'(inc_ext);
    prev_nx = (cur_sat == '0) ? fc_m1 : cur_sat - FRAME_BITS'(1);

    // ping-pong step
    ping_rev = rev_q;
    if (fc_eff == FC_W'(1)) begin
      ping_nx = '0;
    end else if (rev_q) begin
      if (cur_sat == '0) begin
        ping_nx  = FRAME_BITS'(1);
        ping_rev = 1'b0;
      end else begin
        ping_nx = cur_sat - FRAME_BITS'(1);
      end
    end else if (cur_sat == fc_m1) begin
      ping_nx  = fc_m2;
      ping_rev = 1'b1;
    end else begin
      ping_nx = FRAME_BITS'(inc_ext);
    end

    if (mode_q == sfs_pkg::MODE_PING) begin
      tick_nx  = ping_nx;
      tick_rev = ping_rev;
    end else begin
      tick_nx  = wrap_nx;
      tick_rev = rev_q;
    end

    // elapsed time wraps with the clock width
    elapsed = now_t - last_q;
    due     = (CMP_W'(elapsed) >= CMP_W'(quo_q));
  end

  assign can_finish = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    frame_count_d = frame_count_q;
    interval_d    = interval_q;
    speed_d       = speed_q;
    sprite_ok_d   = sprite_ok_q;
    run_d         = run_q;
    mode_d        = mode_q;
    cur_d         = cur_q;
    rev_d         = rev_q;
    last_d        = last_q;
    played_d      = played_q;
    cmd_d         = cmd_q;
    cnt_d         = cnt_q;
    rem_d         = rem_q;
    quo_d         = quo_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_d         = out_q;

    // register writes must arrive only while idle; this block does not enforce it
    if (cfg_we_i) begin
      case (cfg_index_i)
        sfs_pkg::CFG_FRAME_COUNT: frame_count_d = cfg_data_i;
        sfs_pkg::CFG_INTERVAL:    interval_d    = cfg_data_i;
        sfs_pkg::CFG_SPEED: begin
          if (cfg_data_i[SPEED_W-1:0] < sfs_pkg::SPEED_MIN) begin
            speed_d = sfs_pkg::SPEED_MIN;
          end else if (cfg_data_i[SPEED_W-1:0] > sfs_pkg::SPEED_MAX) begin
            speed_d = sfs_pkg::SPEED_MAX;
          end else begin
            speed_d = cfg_data_i[SPEED_W-1:0];
          end
        end
        sfs_pkg::CFG_SPRITE_OK:   sprite_ok_d = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_item_i;
          rem_d   = '0;
          quo_d   = {interval_q, 8'd0};
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end

      ST_DIV: begin
        // frame time = (interval << 8) / speed, one quotient bit per cycle
        rem_d = div_ge ? SPEED_W'(div_sh - {1'b0, speed_q}) : div_sh[SPEED_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], div_ge};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QUO_W - 1)) begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (can_finish) begin
          out_valid_d       = 1'b1;
          out_d.advanced    = 1'b0;
          out_d.accepted    = 1'b0;
          out_d.redraw      = 1'b0;
          state_d           = ST_IDLE;
          if (sprite_ok_q) begin
            cur_d = cur_sat;
            case (cmd_q.kind)
              sfs_pkg::KIND_TICK: begin
                if (run_q == sfs_pkg::RUN_PLAYING && due) begin
                  if (mode_q == sfs_pkg::MODE_ONCE && tick_nx == '0 &&
                      cur_sat == fc_m1) begin
                    // end of a once run
                    run_d        = sfs_pkg::RUN_LOADED;
                    cur_d        = '0;
                    rev_d        = 1'b0;
                    out_d.redraw = 1'b1;
                  end else begin
                    cur_d          = tick_nx;
                    rev_d          = tick_rev;
                    last_d         = now_t;
                    played_d       = played_q + 32'd1;
                    out_d.advanced = 1'b1;
                    out_d.redraw   = 1'b1;
                  end
                end
              end
              sfs_pkg::KIND_PLAY: begin
                mode_d = (cmd_q.loop_mode == sfs_pkg::MODE_ALT) ? sfs_pkg::MODE_LOOP
                                                                : sfs_pkg::loop_mode_e'(cmd_q.loop_mode);
                run_d          = sfs_pkg::RUN_PLAYING;
                cur_d          = '0;
                rev_d          = 1'b0;
                last_d         = now_t;
                played_d       = 32'd0;
                out_d.accepted = 1'b1;
                out_d.redraw   = 1'b1;
              end
              sfs_pkg::KIND_PAUSE: begin
                if (run_q == sfs_pkg::RUN_PLAYING) begin
                  run_d = sfs_pkg::RUN_PAUSED;
                end
              end
              sfs_pkg::KIND_RESUME: begin
                if (run_q == sfs_pkg::RUN_PAUSED) begin
                  run_d  = sfs_pkg::RUN_PLAYING;
                  last_d = now_t;
                end
              end
              sfs_pkg::KIND_STOP: begin
                run_d        = sfs_pkg::RUN_LOADED;
                cur_d        = '0;
                rev_d        = 1'b0;
                out_d.redraw = 1'b1;
              end
              sfs_pkg::KIND_GOTO: begin
                if ({1'b0, cmd_q.target_frame} < 17'(fc_eff)) begin
                  cur_d        = FRAME_BITS'(cmd_q.target_frame);
                  out_d.redraw = 1'b1;
                end
              end
              sfs_pkg::KIND_NEXT: begin
                cur_d        = wrap_nx;
                out_d.redraw = 1'b1;
              end
              sfs_pkg::KIND_PREV: begin
                cur_d        = prev_nx;
                out_d.redraw = 1'b1;
              end
              sfs_pkg::KIND_RESET_STATS: played_d = 32'd0;
              default: ;
            endcase
            out_d.frame_index   = 16'(cur_d);
            out_d.run_state     = run_d;
            out_d.frames_played = played_d;
          end else begin
            // error: state frozen, item ignored
            out_d.frame_index   = 16'(cur_q);
            out_d.run_state     = sfs_pkg::RUN_ERROR;
            out_d.frames_played = played_q;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      frame_count_q <= sfs_pkg::FRAME_COUNT_RST;
      interval_q    <= sfs_pkg::INTERVAL_RST;
      speed_q       <= sfs_pkg::SPEED_RST;
      sprite_ok_q   <= 1'b1;
      run_q         <= sfs_pkg::RUN_LOADED;
      mode_q        <= sfs_pkg::MODE_ONCE;
      cur_q         <= '0;
      rev_q         <= 1'b0;
      last_q        <= '0;
      played_q      <= '0;
      cnt_q         <= '0;
      rem_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      frame_count_q <= frame_count_d;
      interval_q    <= interval_d;
      speed_q       <= speed_d;
      sprite_ok_q   <= sprite_ok_d;
      run_q         <= run_d;
      mode_q        <= mode_d;
      cur_q         <= cur_d;
      rev_q         <= rev_d;
      last_q        <= last_d;
      played_q      <= played_d;
      cnt_q         <= cnt_d;
      rem_q         <= rem_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    quo_q <= quo_d;
    out_q <= out_d;
  end

  // accepted item starts the divider
  `SFS_ASSERT_NEXT(a_accept_div, in_valid_i && in_ready_o, state_q == ST_DIV,
                   "accepted item did not start the divide")
  // the partial remainder stays below the divisor
  `SFS_ASSERT(a_rem_bound, (state_q == ST_DIV) |-> (rem_q < speed_q),
              "divider remainder out of range")
  // a result appears only from the update step
  `SFS_ASSERT(a_out_from_fin, $rose(out_valid_o) |-> $past(state_q == ST_FIN),
              "result valid without an update step")
  // a taken play always reports playing
  `SFS_ASSERT(a_play_state, (out_valid_o && out_item_o.accepted) |->
              (out_item_o.run_state == sfs_pkg::RUN_PLAYING),
              "accepted play without playing state")

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import sfs_pkg::*;

  // tracks the sequencer state from accepted commands and checks every result item
  class frame_scoreboard;
    logic [15:0] count_cfg;
    logic [15:0] interval_cfg;
    logic [11:0] speed_cfg;
    logic        sprite_ok_cfg;

    run_state_e  state;
    loop_mode_e  mode;
    logic [15:0] frame;
    logic        backward;
    logic [31:0] last_ms;
    logic [31:0] played;

    res_item_t   expected_frames[$];
    int unsigned errors;
    int unsigned n_cmds;

    function new();
      count_cfg     = FRAME_COUNT_RST;
      interval_cfg  = INTERVAL_RST;
      speed_cfg     = SPEED_RST;
      sprite_ok_cfg = 1'b1;
      state         = RUN_LOADED;
      mode          = MODE_ONCE;
      frame         = '0;
      backward      = 1'b0;
      last_ms       = '0;
      played        = '0;
      errors        = 0;
      n_cmds        = 0;
    endfunction

    function void write_cfg(cfg_index_e idx, logic [15:0] val);
      case (idx)
        CFG_FRAME_COUNT: count_cfg = val;
        CFG_INTERVAL:    interval_cfg = val;
        CFG_SPEED: begin
          if (val[11:0] < SPEED_MIN) speed_cfg = SPEED_MIN;
          else if (val[11:0] > SPEED_MAX) speed_cfg = SPEED_MAX;
          else speed_cfg = val[11:0];
        end
        CFG_SPRITE_OK:   sprite_ok_cfg = val[0];
        default: ;
      endcase
    endfunction

    // ms between frames at the current speed, truncated
    function logic [31:0] frame_time();
      return ({16'd0, interval_cfg} << 8) / {20'd0, speed_cfg};
    endfunction

    function void note_command(cmd_item_t c);
      logic [16:0] fc;
      logic [15:0] nx;
      logic        flip;
      res_item_t   r;
      r = '0;
      n_cmds++;
      if (sprite_ok_cfg) begin
        fc = (count_cfg == 16'd0) ? 17'd1 : {1'b0, count_cfg};
        if ({1'b0, frame} >= fc) frame = fc[15:0] - 16'd1;
        case (c.kind)
          KIND_TICK: begin
            if (state == RUN_PLAYING && c.now_ms - last_ms >= frame_time()) begin
              flip = backward;
              if (mode != MODE_PING) begin
                nx = ({1'b0, frame} + 17'd1 >= fc) ? 16'd0 : frame + 16'd1;
              end else if (fc == 17'd1) begin
                nx = 16'd0;
              end else if (backward) begin
                if (frame == 16'd0) begin
                  flip = 1'b0;
                  nx = 16'd1;
                end else begin
                  nx = frame - 16'd1;
                end
              end else if ({1'b0, frame} == fc - 17'd1) begin
                flip = 1'b1;
                nx = fc[15:0] - 16'd2;
              end else begin
                nx = frame + 16'd1;
              end
              backward = flip;
              if (mode == MODE_ONCE && nx == 16'd0 && {1'b0, frame} == fc - 17'd1) begin
                state    = RUN_LOADED;
                frame    = '0;
                backward = 1'b0;
              end else begin
                frame      = nx;
                last_ms    = c.now_ms;
                played     = played + 32'd1;
                r.advanced = 1'b1;
              end
              r.redraw = 1'b1;
            end
          end
          KIND_PLAY: begin
            mode     = (c.loop_mode == MODE_ALT) ? MODE_LOOP : loop_mode_e'(c.loop_mode);
            state    = RUN_PLAYING;
            frame    = '0;
            backward = 1'b0;
            last_ms  = c.now_ms;
            played   = '0;
            r.accepted = 1'b1;
            r.redraw   = 1'b1;
          end
          KIND_PAUSE: if (state == RUN_PLAYING) state = RUN_PAUSED;
          KIND_RESUME: begin
            if (state == RUN_PAUSED) begin
              state   = RUN_PLAYING;
              last_ms = c.now_ms;
            end
          end
          KIND_STOP: begin
            state    = RUN_LOADED;
            frame    = '0;
            backward = 1'b0;
            r.redraw = 1'b1;
          end
          KIND_GOTO: begin
            if ({1'b0, c.target_frame} < fc) begin
              frame    = c.target_frame;
              r.redraw = 1'b1;
            end
          end
          KIND_NEXT: begin
            frame    = ({1'b0, frame} + 17'd1 >= fc) ? 16'd0 : frame + 16'd1;
            r.redraw = 1'b1;
          end
          KIND_PREV: begin
            frame    = (frame == 16'd0) ? fc[15:0] - 16'd1 : frame - 16'd1;
            r.redraw = 1'b1;
          end
          KIND_RESET_STATS: played = '0;
          default: ;
        endcase
        r.run_state = state;
      end else begin
        r.run_state = RUN_ERROR;
      end
      r.frame_index   = frame;
      r.frames_played = played;
      expected_frames.push_back(r);
    endfunction

    function void check_result(res_item_t got);
      res_item_t want;
      if (expected_frames.size() == 0) begin
        if (errors < 10) $display("[%0t] result item with nothing outstanding", $time);
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      if (got.frame_index !== want.frame_index || got.run_state !== want.run_state ||
          got.advanced !== want.advanced || got.accepted !== want.accepted ||
          got.redraw !== want.redraw || got.frames_played !== want.frames_played) begin
        if (errors < 10) begin
          $display("[%0t] mismatch (exp/got): frame %0d/%0d state %0d/%0d adv %0b/%0b",
                   $time, want.frame_index, got.frame_index, want.run_state,
                   got.run_state, want.advanced, got.advanced);
          $display("    acc %0b/%0b redraw %0b/%0b played %0d/%0d",
                   want.accepted, got.accepted, want.redraw, got.redraw,
                   want.frames_played, got.frames_played);
        end
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  cmd_item_t             in_item_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  res_item_t             out_item_o;
  logic                  cfg_we_i;
  logic [1:0]            cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  frame_scoreboard sb = new();
  int unsigned     idle_pct = 6;
  logic [31:0]     now_t;
  bit              long_hold_done = 1'b0;

  sprite_frame_sequencer dut (.*);

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // both handshakes are sampled with the values present just before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_item_o);
      if (in_valid_i && in_ready_o) sb.note_command(in_item_i);
    end
  end

  // result side: random back-pressure, plus one long hold once the run is well along
  // so the output register fills and the command side stalls
  initial begin : result_sink
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && sb.n_cmds >= 500) begin
        out_ready_i <= 1'b0;
        repeat (600) @(negedge clk_i);
        long_hold_done = 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // offer one command item and hold it until taken; returns on the following falling edge
  task automatic issue(input logic [3:0] k, input logic [31:0] t, input logic [1:0] m,
                       input logic [15:0] tgt);
    if ($urandom_range(99) < idle_pct * 5 / 2) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{kind: k, now_ms: t, loop_mode: m, target_frame: tgt};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_frames.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    sb.write_cfg(idx, val);
    @(negedge clk_i);
  endtask

  // registers only change while the sequencer is idle
  task automatic load_config(input logic [15:0] cnt, input logic [15:0] ivl,
                             input logic [15:0] spd, input logic ok);
    drain();
    write_reg(CFG_FRAME_COUNT, cnt);
    write_reg(CFG_INTERVAL, ivl);
    write_reg(CFG_SPEED, spd);
    write_reg(CFG_SPRITE_OK, {15'd0, ok});
    cfg_we_i <= 1'b0;
  endtask

  // mostly ticks with time moving around the frame period, so playback runs deep;
  // the rest are control commands, random gotos, time jumps and unused kinds
  task automatic random_cmds(input int unsigned n);
    int unsigned r;
    logic [31:0] period;
    logic [15:0] tgt;
    for (int i = 0; i < n; i++) begin
      period = sb.frame_time();
      r = $urandom_range(99);
      if ($urandom_range(99) < 3) now_t = $urandom;
      if (r < 55) begin
        now_t = now_t + $urandom_range(0, period + period / 2 + 1);
        issue(KIND_TICK, now_t, 2'($urandom), 16'($urandom));
      end else if (r < 63) begin
        issue(KIND_PLAY, now_t, 2'($urandom), 16'($urandom));
      end else if (r < 68) begin
        issue(KIND_PAUSE, now_t, 2'($urandom), 16'($urandom));
      end else if (r < 73) begin
        now_t = now_t + $urandom_range(0, period);
        issue(KIND_RESUME, now_t, 2'($urandom), 16'($urandom));
      end else if (r < 76) begin
        issue(KIND_STOP, now_t, 2'($urandom), 16'($urandom));
      end else if (r < 82) begin
        // half the gotos land inside the sheet
        if ($urandom_range(1)) tgt = 16'($urandom);
        else tgt = 16'($urandom_range(0, (sb.count_cfg == 16'd0) ? 0 : sb.count_cfg - 1));
        issue(KIND_GOTO, now_t, 2'($urandom), tgt);
      end else if (r < 87) begin
        issue(KIND_NEXT, now_t, 2'($urandom), 16'($urandom));
      end else if (r < 92) begin
        issue(KIND_PREV, now_t, 2'($urandom), 16'($urandom));
      end else if (r < 95) begin
        issue(KIND_RESET_STATS, now_t, 2'($urandom), 16'($urandom));
      end else begin
        issue(4'(KIND_RESET_STATS) + 4'($urandom_range(1, 7)), $urandom, 2'($urandom),
              16'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_FRAME_COUNT;
    cfg_data_i  = '0;
    now_t       = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: one frame, 33 ms period
    issue(KIND_PLAY, 32'd100, MODE_ONCE, 16'($urandom));
    issue(KIND_TICK, 32'd133, 2'($urandom), 16'($urandom));   // single frame once: stops
    issue(KIND_PLAY, 32'd200, MODE_PING, 16'($urandom));
    issue(KIND_TICK, 32'd233, 2'($urandom), 16'($urandom));   // single frame ping-pong holds
    issue(KIND_PLAY, 32'd300, MODE_ALT, 16'($urandom));       // mode three acts as loop
    issue(KIND_TICK, 32'd332, 2'($urandom), 16'($urandom));   // one ms short
    issue(KIND_TICK, 32'd333, 2'($urandom), 16'($urandom));

    // three frames, 1 ms period
    load_config(16'd3, 16'd1, 16'd256, 1'b1);
    issue(KIND_PLAY, 32'd1000, MODE_ONCE, 16'($urandom));
    issue(KIND_TICK, 32'd1001, 2'($urandom), 16'($urandom));
    issue(KIND_TICK, 32'd1002, 2'($urandom), 16'($urandom));
    issue(KIND_TICK, 32'd1003, 2'($urandom), 16'($urandom)); // end of once mode
    issue(KIND_PLAY, 32'd2000, MODE_PING, 16'($urandom));
    for (int t = 2001; t <= 2005; t++)                        // turns at both ends
      issue(KIND_TICK, t, 2'($urandom), 16'($urandom));
    issue(KIND_PAUSE, 32'd2006, 2'($urandom), 16'($urandom));
    issue(KIND_RESUME, 32'd2200, 2'($urandom), 16'($urandom));
    issue(KIND_GOTO, 32'd2201, 2'($urandom), 16'd3);          // out of range, ignored
    issue(KIND_STOP, 32'd2202, 2'($urandom), 16'($urandom));
    issue(KIND_GOTO, 32'd2203, 2'($urandom), 16'd2);
    issue(KIND_NEXT, 32'd2204, 2'($urandom), 16'($urandom));  // wraps to 0
    issue(KIND_PREV, 32'd2205, 2'($urandom), 16'($urandom));  // wraps to last
    issue(KIND_RESET_STATS, 32'd2206, 2'($urandom), 16'($urandom));
    issue(4'(KIND_RESET_STATS) + 4'd7, 32'hFFFF_FFFF, 2'($urandom), 16'hFFFF);
    issue(KIND_GOTO, 32'd2207, 2'($urandom), 16'd2);          // left on frame 2

    // shrink to one frame: frame 2 saturates; time starts just below the wrap
    load_config(16'd1, 16'd33, 16'd256, 1'b1);
    now_t = 32'hFFFF_FF00;
    random_cmds(90);
    load_config(16'd5, 16'd20, 16'd256, 1'b1);
    random_cmds(90);
    // full sheet, top speed (upper data bits dropped, clamps high), zero period
    load_config(16'hFFFF, 16'd1, 16'hFFFF, 1'b1);
    random_cmds(90);
    // zero count and zero interval, speed clamps low
    load_config(16'd0, 16'd0, 16'hF000, 1'b1);
    random_cmds(90);
    load_config(16'd2, 16'hFFFF, 16'd2560, 1'b1);
    random_cmds(90);
    load_config(16'd9, 16'd100, 16'd26, 1'b1);
    random_cmds(90);
    // error state: everything frozen
    load_config(16'd6, 16'd12, 16'd300, 1'b0);
    random_cmds(90);
    load_config(16'd3, 16'd40, 16'd512, 1'b1);
    random_cmds(90);
    // last stretch runs with no idling on either side
    load_config(16'd7, 16'd16, 16'd256, 1'b1);
    idle_pct = 0;
    random_cmds(90);

    drain();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin : watchdog
    #(5_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
